@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that an expression never holds outside reset.
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, expr) \
  `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

@@ rtl/core/hcfp_pkg.sv @@
// Shared types, character constants and byte classifiers of the frame parser.
package hcfp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned FrameDigits = ValueW / NibbleW;
  localparam int unsigned CountW    = $clog2(FrameDigits);
  localparam logic [CountW-1:0] LastDigit = CountW'(FrameDigits - 1);

  // ASCII codes used by the parser
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChUpG   = 8'h47;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5A;
  localparam logic [ByteW-1:0] ChLoG   = 8'h67;
  localparam logic [ByteW-1:0] ChLoZ   = 8'h7A;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpF   = 8'h46;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // One result item: channel and assembled value
  typedef struct packed {
    logic [ByteW-1:0]  channel;
    logic [ValueW-1:0] value;
  } result_t;

  function automatic logic is_command(input logic [ByteW-1:0] b);
    return (b inside {[ChUpG:ChUpZ], [ChLoG:ChLoZ], ChPlus, ChMinus});
  endfunction

  function automatic logic is_lower_channel(input logic [ByteW-1:0] b);
    return (b inside {[ChLoG:ChLoZ]});
  endfunction

  function automatic logic is_terminator(input logic [ByteW-1:0] b);
    return (b inside {ChCr, ChLf, ChPlus});
  endfunction

  function automatic logic is_hex_digit(input logic [ByteW-1:0] b);
    return (b inside {[ChZero:ChNine], [ChUpA:ChUpF]});
  endfunction

  // Nibble value of an uppercase hex digit; zero for any other byte
  function automatic logic [NibbleW-1:0] hex_value(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] diff;
    diff = '0;
    if (b inside {[ChZero:ChNine]}) begin
      diff = b - ChZero;
    end else if (b inside {[ChUpA:ChUpF]}) begin
      diff = b - ChUpA + 8'd10;
    end
    return diff[NibbleW-1:0];
  endfunction

endpackage

@@ rtl/core/hcfp_ifs.sv @@
// Valid/ready channel interfaces for received bytes and result items.
interface hcfp_rx_if;
  logic                           valid;
  logic                           ready;
  logic [hcfp_pkg::ByteW-1:0]     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcfp_res_if;
  logic                           valid;
  logic                           ready;
  logic [hcfp_pkg::ByteW-1:0]     channel;
  logic [hcfp_pkg::ValueW-1:0]    value;

  modport source (output valid, output channel, output value, input ready);
  modport sink   (input valid, input channel, input value, output ready);
endinterface

@@ rtl/core/hcfp_in_stage.sv @@
// Input register: captures one received byte and holds it until the decoder takes it.
module hcfp_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hcfp_rx_if.sink                    rx_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [hcfp_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [hcfp_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       load;

  // Accept a new item whenever the slot is empty or drains this cycle
  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = 1'b1;
      byte_d  = rx_i.rx_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

@@ rtl/core/hcfp_decode.sv @@
// Frame state and byte decoder: opens frames, shifts in digits, emits results.
module hcfp_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [hcfp_pkg::ByteW-1:0] byte_i,
  input  logic                       slot_free_i,
  output logic                       take_o,
  output logic                       res_valid_o,
  output hcfp_pkg::result_t          res_o
);

  logic                          in_frame_q, in_frame_d;
  logic [hcfp_pkg::CountW-1:0]   count_q, count_d;
  logic [hcfp_pkg::ByteW-1:0]    channel_q, channel_d;
  logic [hcfp_pkg::ValueW-1:0]   value_q, value_d;

  logic                          is_digit;
  logic                          is_term;
  logic [hcfp_pkg::ValueW-1:0]   shifted;
  logic                          done;

  // Take the held byte whenever the result register can absorb its outcome
  assign take_o = valid_i && slot_free_i;

  // Classify the byte against the current frame
  assign is_digit = hcfp_pkg::is_hex_digit(byte_i);
  assign is_term  = hcfp_pkg::is_lower_channel(channel_q) && hcfp_pkg::is_terminator(byte_i);
  assign shifted  = {value_q[hcfp_pkg::ValueW-hcfp_pkg::NibbleW-1:0],
                     hcfp_pkg::hex_value(byte_i)};

  // Advance the frame state for the taken byte
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    channel_d  = channel_q;
    value_d    = value_q;
    done       = 1'b0;
    if (take_o) begin
      if (!in_frame_q) begin
        if (hcfp_pkg::is_command(byte_i)) begin
          in_frame_d = 1'b1;
          count_d    = '0;
          channel_d  = byte_i;
          value_d    = '0;
        end
      end else if (is_digit) begin
        value_d = shifted;
        if (count_q == hcfp_pkg::LastDigit) begin
          done       = 1'b1;
          in_frame_d = 1'b0;
          count_d    = '0;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else if (is_term) begin
        done       = 1'b1;
        in_frame_d = 1'b0;
        count_d    = '0;
      end else begin
        // drop the frame; this byte does not open a new one
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    channel_q <= channel_d;
    value_q   <= value_d;
  end

  // Full frame carries the last digit; an early end carries the digits so far
  assign res_valid_o   = done;
  assign res_o.channel = channel_q;
  assign res_o.value   = is_digit ? shifted : value_q;

endmodule

@@ rtl/core/hcfp_out_stage.sv @@
// Result register: holds one result item until the downstream side takes it.
module hcfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcfp_pkg::result_t res_i,
  output logic              slot_free_o,
  hcfp_res_if.source        res_o
);

  logic              valid_q, valid_d;
  hcfp_pkg::result_t data_q, data_d;

  // Slot is usable when empty or being drained this cycle
  assign slot_free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign res_o.valid   = valid_q;
  assign res_o.channel = data_q.channel;
  assign res_o.value   = data_q.value;

endmodule

@@ rtl/core/hex_channel_frame_parser.sv @@
// Top level of the hex channel frame parser.
//
//   channel | direction | payload                 | handshake
//   rx_i    | in        | rx_byte[7:0]            | valid / ready
//   res_o   | out       | channel[7:0], value[31:0] | valid / ready
//
// One byte per cycle sustained while the result is not stalled; the byte that
// completes a frame passes the input register, then the result register, from
// which the result can be taken.
// The decoder takes the held byte whenever the result register has room, so the
// frame state loop sets the rate at one item per clock.
// rst_ni clears the frame state and both valid flags asynchronously.
// A stalled result holds its register; the input register keeps accepting
// until one byte waits behind the held result.
module hex_channel_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcfp_rx_if.sink     rx_i,
  hcfp_res_if.source  res_o
);

  logic                       in_valid;
  logic [hcfp_pkg::ByteW-1:0] in_byte;
  logic                       take;
  logic                       slot_free;
  logic                       res_valid;
  hcfp_pkg::result_t          res;

  // Register the received byte
  hcfp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  // Decode the byte against the frame state
  hcfp_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .byte_i      (in_byte),
    .slot_free_i (slot_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register the result item
  hcfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .res_o       (res_o)
  );

endmodule

@@ rtl/core/hcfp_checker.sv @@
// Port-level checker for the frame parser and its bind to the top level.
`include "assert_macros.svh"

module hcfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rx_valid_i,
  input logic                        rx_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [hcfp_pkg::ByteW-1:0]  res_channel_i,
  input logic [hcfp_pkg::ValueW-1:0] res_value_i
);

  logic rx_acc;
  logic res_stall;
  logic res_bad_ch;
  assign rx_acc     = rx_valid_i && rx_ready_i;
  assign res_stall  = res_valid_i && !res_ready_i;
  assign res_bad_ch = res_valid_i && !hcfp_pkg::is_command(res_channel_i);

  // Hold a stalled result item
  `ASSERT_CLK(res_valid_hold, clk_i, rst_ni, res_stall |=> res_valid_i)
  `ASSERT_CLK(res_data_hold, clk_i, rst_ni, res_stall |=> $stable({res_channel_i, res_value_i}))

  // Every result names a channel that can open a frame
  `ASSERT_NEVER_CLK(res_channel_cmd, clk_i, rst_ni, res_bad_ch)

  // A result out of an empty register comes from a byte that passed straight through the input register
  `ASSERT_CLK(res_from_accept, clk_i, rst_ni, $rose(res_valid_i) |-> $past(rx_acc, 2))

endmodule

bind hex_channel_frame_parser hcfp_checker u_hcfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_i.valid),
  .rx_ready_i    (rx_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_channel_i (res_o.channel),
  .res_value_i   (res_o.value)
);
